// File: rtl/vn_pkg.sv
// ----------------------------------------------------------------------------
// vn_pkg: shared types and constants of the vector normalizer
// Holds the request and result payload structs and the fixed datapath widths.
// ----------------------------------------------------------------------------
`default_nettype none

package vn_pkg;

  localparam int CompWidth  = 16;
  localparam int FracBits   = 14;
  localparam int UnitWidth  = FracBits + 2;
  localparam int SqWidth    = 2 * CompWidth;
  localparam int SumWidth   = 2 * CompWidth + 2;
  // One root bit per stage; the sum is consumed two bits at a time.
  localparam int RootSteps  = SumWidth / 2;
  // One quotient bit per stage; the quotient never exceeds 2^FracBits.
  localparam int QuotSteps  = FracBits + 1;
  localparam int NumLanes   = 3;

  typedef struct packed {
    logic signed [CompWidth-1:0] x_comp;
    logic signed [CompWidth-1:0] y_comp;
    logic signed [CompWidth-1:0] z_comp;
  } vn_in_t;

  typedef struct packed {
    logic        [CompWidth-1:0] length;
    logic signed [UnitWidth-1:0] unit_x;
    logic signed [UnitWidth-1:0] unit_y;
    logic signed [UnitWidth-1:0] unit_z;
    logic                        zero_vector;
  } vn_out_t;

endpackage

`default_nettype wire

// File: rtl/vector3_normalize_top.sv
// ----------------------------------------------------------------------------
// vector3_normalize_top: 3D integer vector normalizer
// Length by integer square root and unit components in Q1.14 per request.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_ready_o is high and returns
// one result per request, in order. The request passes 35 pipeline registers:
// a square stage, a sum stage, 17 square root stages (one root bit each),
// 15 division stages (one quotient bit each, three lanes side by side) and
// the output register. Every stage only holds when the stage after it is
// full and stalled, so requests keep flowing into empty slots while a
// finished result waits at the output.
`default_nettype none

module vector3_normalize_top import vn_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          in_valid_i,
  output logic         in_ready_o,
  input  wire vn_in_t  in_req_i,
  output logic         out_valid_o,
  input  wire          out_ready_i,
  output vn_out_t      out_rsp_o
);

  localparam int CarrySteps = RootSteps + QuotSteps;
  localparam int NumStages  = 2 + CarrySteps + 1;
  localparam int OutStage   = NumStages - 1;
  localparam int DivBase    = 2 + RootSteps;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  always_comb begin
    en[OutStage] = !valid_q[OutStage] || out_ready_i;
    for (int k = OutStage - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // Square lanes
  logic signed [CompWidth-1:0] comp_in [NumLanes];
  logic [CompWidth-1:0] lane_mag [NumLanes];
  logic                 lane_neg [NumLanes];
  logic [SqWidth-1:0]   lane_sq  [NumLanes];

  assign comp_in[0] = in_req_i.x_comp;
  assign comp_in[1] = in_req_i.y_comp;
  assign comp_in[2] = in_req_i.z_comp;

  for (genvar l = 0; l < NumLanes; l++) begin : g_sq
    vn_square_lane u_sq (
      .clk_i  (clk_i),
      .en_i   (en[0]),
      .comp_i (comp_in[l]),
      .mag_q  (lane_mag[l]),
      .neg_q  (lane_neg[l]),
      .sq_q   (lane_sq[l])
    );
  end

  // Sign and magnitude travel alongside the root and quotient stages.
  logic [CompWidth-1:0] mag_p [CarrySteps+1][NumLanes];
  logic                 neg_p [CarrySteps+1][NumLanes];
  logic [SumWidth-1:0]  sum_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sum_q <= SumWidth'(lane_sq[0]) + SumWidth'(lane_sq[1]) + SumWidth'(lane_sq[2]);
    end
  end

  for (genvar p = 0; p <= CarrySteps; p++) begin : g_carry
    if (p == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[1]) begin
          for (int l = 0; l < NumLanes; l++) begin
            mag_p[0][l] <= lane_mag[l];
            neg_p[0][l] <= lane_neg[l];
          end
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[1+p]) begin
          for (int l = 0; l < NumLanes; l++) begin
            mag_p[p][l] <= mag_p[p-1][l];
            neg_p[p][l] <= neg_p[p-1][l];
          end
        end
      end
    end
  end

  // Square root
  logic [SumWidth-1:0]  sr_sum  [RootSteps+1];
  logic [SumWidth-1:0]  sr_rem  [RootSteps+1];
  logic [RootSteps-1:0] sr_root [RootSteps+1];

  assign sr_sum[0]  = sum_q;
  assign sr_rem[0]  = '0;
  assign sr_root[0] = '0;

  for (genvar k = 0; k < RootSteps; k++) begin : g_sqrt
    vn_sqrt_stage u_st (
      .clk_i  (clk_i),
      .en_i   (en[2+k]),
      .rem_i  (sr_rem[k]),
      .root_i (sr_root[k]),
      .pair_i (sr_sum[k][SumWidth-1-2*k -: 2]),
      .rem_q  (sr_rem[k+1]),
      .root_q (sr_root[k+1])
    );
    always_ff @(posedge clk_i) begin
      if (en[2+k]) begin
        sr_sum[k+1] <= sr_sum[k];
      end
    end
  end

  // Division lanes
  logic [CompWidth-1:0] dv_len  [QuotSteps+1];
  logic [CompWidth:0]   dv_rem  [QuotSteps+1][NumLanes];
  logic [FracBits:0]    dv_quot [QuotSteps+1][NumLanes];

  assign dv_len[0] = sr_root[RootSteps][CompWidth-1:0];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    logic [CompWidth-1:0] mag0;
    assign mag0             = mag_p[RootSteps][l];
    assign dv_rem[0][l]     = {2'b00, mag0[CompWidth-1:1]};
    assign dv_quot[0][l]    = '0;
    for (genvar j = 0; j < QuotSteps; j++) begin : g_div
      vn_div_stage u_dv (
        .clk_i  (clk_i),
        .en_i   (en[DivBase+j]),
        .rem_i  (dv_rem[j][l]),
        .bit_i  ((j == 0) ? mag_p[RootSteps+j][l][0] : 1'b0),
        .len_i  (dv_len[j]),
        .quot_i (dv_quot[j][l]),
        .rem_q  (dv_rem[j+1][l]),
        .quot_q (dv_quot[j+1][l])
      );
    end
  end

  for (genvar j = 0; j < QuotSteps; j++) begin : g_len
    always_ff @(posedge clk_i) begin
      if (en[DivBase+j]) begin
        dv_len[j+1] <= dv_len[j];
      end
    end
  end

  // Sign, clamp and zero-vector handling
  logic [UnitWidth-1:0] unit_d [NumLanes];
  logic                 zero_d;
  vn_out_t              out_q;

  assign zero_d = (dv_len[QuotSteps] == '0);

  always_comb begin
    logic [UnitWidth-1:0] qv;
    for (int l = 0; l < NumLanes; l++) begin
      qv = UnitWidth'(dv_quot[QuotSteps][l]);
      if (qv > (UnitWidth'(1) << FracBits)) begin
        qv = UnitWidth'(1) << FracBits;
      end
      if (zero_d) begin
        unit_d[l] = '0;
      end else begin
        unit_d[l] = neg_p[CarrySteps][l] ? (~qv + 1'b1) : qv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OutStage]) begin
      out_q.length      <= dv_len[QuotSteps];
      out_q.unit_x      <= unit_d[0];
      out_q.unit_y      <= unit_d[1];
      out_q.unit_z      <= unit_d[2];
      out_q.zero_vector <= zero_d;
    end
  end

  assign out_valid_o = valid_q[OutStage];
  assign out_rsp_o   = out_q;

endmodule

`default_nettype wire

// File: rtl/vn_square_lane.sv
// ----------------------------------------------------------------------------
// vn_square_lane: magnitude and square of one component
// Splits a two's complement component into sign and magnitude and registers
// the magnitude together with its square.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_square_lane import vn_pkg::*; (
  input  wire                          clk_i,
  input  wire                          en_i,
  input  wire  signed [CompWidth-1:0]  comp_i,
  output logic        [CompWidth-1:0]  mag_q,
  output logic                         neg_q,
  output logic        [SqWidth-1:0]    sq_q
);

  logic [CompWidth-1:0] mag_d;
  logic                 neg_d;

  // The most negative value maps onto itself, which is its correct magnitude.
  assign neg_d = comp_i[CompWidth-1];
  assign mag_d = neg_d ? (~comp_i + 1'b1) : comp_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      sq_q  <= SqWidth'(mag_d) * SqWidth'(mag_d);
    end
  end

endmodule

`default_nettype wire

// File: rtl/vn_sqrt_stage.sv
// ----------------------------------------------------------------------------
// vn_sqrt_stage: one digit step of the integer square root
// Brings down two bits of the radicand and decides one root bit.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_sqrt_stage import vn_pkg::*; (
  input  wire                    clk_i,
  input  wire                    en_i,
  input  wire  [SumWidth-1:0]    rem_i,
  input  wire  [RootSteps-1:0]   root_i,
  input  wire  [1:0]             pair_i,
  output logic [SumWidth-1:0]    rem_q,
  output logic [RootSteps-1:0]   root_q
);

  logic [SumWidth-1:0]  rem_sh;
  logic [SumWidth-1:0]  trial;
  logic [SumWidth-1:0]  rem_d;
  logic [RootSteps-1:0] root_d;

  always_comb begin
    rem_sh = {rem_i[SumWidth-3:0], pair_i};
    trial  = {{(SumWidth-RootSteps-2){1'b0}}, root_i, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_i[RootSteps-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_i[RootSteps-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/vn_div_stage.sv
// ----------------------------------------------------------------------------
// vn_div_stage: one restoring division step of a lane
// Shifts in one dividend bit and decides one quotient bit against the length.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_div_stage import vn_pkg::*; (
  input  wire                    clk_i,
  input  wire                    en_i,
  input  wire  [CompWidth:0]     rem_i,
  input  wire                    bit_i,
  input  wire  [CompWidth-1:0]   len_i,
  input  wire  [FracBits:0]      quot_i,
  output logic [CompWidth:0]     rem_q,
  output logic [FracBits:0]      quot_q
);

  logic [CompWidth:0] rem_sh;
  logic [CompWidth:0] rem_d;
  logic [FracBits:0]  quot_d;

  // The remainder stays below the length, so the shifted value fits.
  always_comb begin
    rem_sh = {rem_i[CompWidth-1:0], bit_i};
    if (rem_sh >= {1'b0, len_i}) begin
      rem_d  = rem_sh - {1'b0, len_i};
      quot_d = {quot_i[FracBits-1:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      quot_d = {quot_i[FracBits-1:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/vn_checker.sv
// ----------------------------------------------------------------------------
// vn_checker: port-level checks of the vector normalizer
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`default_nettype none

module vn_checker import vn_pkg::*; (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           in_valid_i,
  input wire           in_ready_o,
  input wire           out_valid_o,
  input wire           out_ready_i,
  input wire vn_out_t  out_rsp_o
);

  localparam logic signed [UnitWidth-1:0] UnitOne = UnitWidth'(1) << FracBits;

  // An empty output slot means the whole pipeline can advance.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("request refused with empty output");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled result changed");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.zero_vector == (out_rsp_o.length == '0)))
    else $error("zero-vector flag disagrees with length");

  a_zero_units: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.zero_vector |->
      out_rsp_o.unit_x == '0 && out_rsp_o.unit_y == '0 && out_rsp_o.unit_z == '0)
    else $error("zero vector with nonzero unit component");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_rsp_o.unit_x <= UnitOne && out_rsp_o.unit_x >= -UnitOne &&
      out_rsp_o.unit_y <= UnitOne && out_rsp_o.unit_y >= -UnitOne &&
      out_rsp_o.unit_z <= UnitOne && out_rsp_o.unit_z >= -UnitOne)
    else $error("unit component out of range");

endmodule

bind vector3_normalize_top vn_checker u_vn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire

// File: bench/vector3_normalize_top_tb.sv
// ----------------------------------------------------------------------------
// vector3_normalize_top_tb: self-checking bench of the vector normalizer
// Drives directed and random requests with random gaps and output stalls,
// predicts length and unit components per request, or takes them from a typed table row, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module vector3_normalize_top_tb;
  import vn_pkg::*;

  localparam int MaxCycles = 200000;
  localparam int Latency   = 35;

  typedef struct {
    vn_in_t  req;
    bit      typed;
    vn_out_t rsp;
  } stim_row_t;

  logic    clk_i = 1'b0;
  logic    rst_ni = 1'b0;
  logic    in_valid_i = 1'b0;
  logic    out_ready_i = 1'b0;
  vn_in_t  in_req_i = '0;
  logic    in_ready_o;
  logic    out_valid_o;
  vn_out_t out_rsp_o;

  vn_out_t expected_rsps[$];
  int      error_count = 0;
  int      cycle_count = 0;
  bit      stim_done = 1'b0;

  vector3_normalize_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] root;
    logic [63:0] bit_w;
    root = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= root + bit_w) begin
        n = n - (root + bit_w);
        root = (root >> 1) + bit_w;
      end else begin
        root >>= 1;
      end
      bit_w >>= 2;
    end
    return root;
  endfunction

  function automatic logic [UnitWidth-1:0] unit_of(logic signed [CompWidth-1:0] c,
                                                    logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = (c < 0) ? 64'(-64'(c)) : 64'(c);
    q = (mag << FracBits) / len;
    if (q > (64'd1 << FracBits)) q = 64'd1 << FracBits;
    if (c < 0) q = -q;
    return q[UnitWidth-1:0];
  endfunction

  function automatic vn_out_t normalize(vn_in_t v);
    vn_out_t r;
    logic [63:0] sum;
    logic [63:0] len;
    sum = 64'(v.x_comp * 64'sd1 * v.x_comp) + 64'(v.y_comp * 64'sd1 * v.y_comp)
        + 64'(v.z_comp * 64'sd1 * v.z_comp);
    len = isqrt(sum);
    r = '0;
    if (len == 0) begin
      r.zero_vector = 1'b1;
    end else begin
      r.length = len[CompWidth-1:0];
      r.unit_x = unit_of(v.x_comp, len);
      r.unit_y = unit_of(v.y_comp, len);
      r.unit_z = unit_of(v.z_comp, len);
    end
    return r;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // Valid stays high across back-to-back requests and drops only for a gap.
  task automatic send_request(vn_in_t v, bit typed, vn_out_t rsp);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= v;
    expected_rsps.push_back(typed ? rsp : normalize(v));
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Output stalls, with quiet stretches where the sink always takes results.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
      stall = gap_len();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    vn_out_t exp_rsp;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) begin
        $error("result with nothing outstanding: %h", out_rsp_o);
        error_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_rsp_o.length !== exp_rsp.length) begin
          $error("length: expected %0d, got %0d", exp_rsp.length, out_rsp_o.length);
          error_count++;
        end
        if (out_rsp_o.unit_x !== exp_rsp.unit_x) begin
          $error("unit_x: expected %0d, got %0d", exp_rsp.unit_x, out_rsp_o.unit_x);
          error_count++;
        end
        if (out_rsp_o.unit_y !== exp_rsp.unit_y) begin
          $error("unit_y: expected %0d, got %0d", exp_rsp.unit_y, out_rsp_o.unit_y);
          error_count++;
        end
        if (out_rsp_o.unit_z !== exp_rsp.unit_z) begin
          $error("unit_z: expected %0d, got %0d", exp_rsp.unit_z, out_rsp_o.unit_z);
          error_count++;
        end
        if (out_rsp_o.zero_vector !== exp_rsp.zero_vector) begin
          $error("zero_vector: expected %0b, got %0b", exp_rsp.zero_vector,
                 out_rsp_o.zero_vector);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MaxCycles) begin
      $display("vector3_normalize_top_tb: done, errors");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    vn_in_t    v;
    int        pick;
    int        drain;

    // Zero vector, single-axis extremes with exact lengths, then predicted rows.
    rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1'b1, '{16'd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}});
    rows.push_back('{'{16'sd32767, 16'sd0, 16'sd0}, 1'b1,
                     '{16'd32767, 16'sd16384, 16'sd0, 16'sd0, 1'b0}});
    rows.push_back('{'{16'sd0, -16'sd32768, 16'sd0}, 1'b1,
                     '{16'd32768, 16'sd0, -16'sd16384, 16'sd0, 1'b0}});
    rows.push_back('{'{16'sd0, 16'sd0, -16'sd1}, 1'b1,
                     '{16'd1, 16'sd0, 16'sd0, -16'sd16384, 1'b0}});
    rows.push_back('{'{16'sd1, 16'sd0, 16'sd0}, 1'b1,
                     '{16'd1, 16'sd16384, 16'sd0, 16'sd0, 1'b0}});
    rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0});
    rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0});
    rows.push_back('{'{-16'sd32768, 16'sd32767, -16'sd32768}, 1'b0, '0});
    rows.push_back('{'{16'sd1, 16'sd1, 16'sd1}, 1'b0, '0});
    rows.push_back('{'{-16'sd1, 16'sd1, -16'sd1}, 1'b0, '0});
    rows.push_back('{'{16'sd3, 16'sd4, 16'sd0}, 1'b0, '0});
    rows.push_back('{'{16'sd1, 16'sd2, 16'sd2}, 1'b0, '0});
    rows.push_back('{'{-16'sd21845, 16'sd10922, 16'sd5461}, 1'b0, '0});
    rows.push_back('{'{16'sd1, 16'sd0, 16'sd32767}, 1'b0, '0});

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      row = rows[i];
      send_request(row.req, row.typed, row.rsp);
    end

    for (int n = 0; n < 400; n++) begin
      pick = $urandom_range(0, 9);
      v.x_comp = CompWidth'($urandom);
      v.y_comp = CompWidth'($urandom);
      v.z_comp = CompWidth'($urandom);
      // Small vectors stress rounding of tiny lengths; axis-aligned ones the full-scale unit value.
      if (pick < 2) begin
        v.x_comp = CompWidth'($signed(4'($urandom)));
        v.y_comp = CompWidth'($signed(4'($urandom)));
        v.z_comp = CompWidth'($signed(4'($urandom)));
      end else if (pick == 2) begin
        v.y_comp = '0;
        v.z_comp = '0;
      end
      send_request(v, 1'b0, '0);
      if (n == 200) begin
        in_valid_i <= 1'b0;
        while (expected_rsps.size() != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    while (expected_rsps.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 2 * Latency) begin
      @(posedge clk_i);
      drain++;
    end
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("vector3_normalize_top_tb: done, clean");
    end else begin
      $display("vector3_normalize_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/vn_pkg.sv
rtl/vn_square_lane.sv
rtl/vn_sqrt_stage.sv
rtl/vn_div_stage.sv
rtl/vector3_normalize_top.sv
rtl/vn_checker.sv
bench/vector3_normalize_top_tb.sv
